FILE: design/bottom_left_3d_box_placer_defines.svh
// Assertion macros for the bottom-left 3D box placer
`ifndef BOTTOM_LEFT_3D_BOX_PLACER_DEFINES_SVH
`define BOTTOM_LEFT_3D_BOX_PLACER_DEFINES_SVH
`define BLP_ASSERT_IMPL(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define BLP_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`endif

FILE: design/blp_pkg.sv
// Shared types and constants for the bottom-left 3D box placer
package blp_pkg;
    localparam int unsigned MAX_BOXES_DEF = 64;
    localparam logic [15:0] CONT_RESET = 16'd1024;
    localparam logic [1:0] REG_LENGTH = 2'd0;
    localparam logic [1:0] REG_WIDTH = 2'd1;
    localparam logic [1:0] REG_HEIGHT = 2'd2;

    typedef struct packed {
        logic load;
        logic cand_start;
        logic cand_next;
        logic scan_start;
        logic scan_next;
    } blp_cmd_t;

    typedef struct packed {
        logic cand_last;
        logic scan_last;
        logic scan_hit;
        logic fits;
    } blp_stat_t;
endpackage

FILE: design/blp_datapath.sv
// Datapath: box table, candidate generator and fit/overlap checker
`include "bottom_left_3d_box_placer_defines.svh"
module blp_datapath #(
    parameter int unsigned MAX_BOXES = blp_pkg::MAX_BOXES_DEF,
    localparam int unsigned IW = $clog2(MAX_BOXES),
    localparam int unsigned CW = $clog2(MAX_BOXES + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  blp_pkg::blp_cmd_t cmd,
    output blp_pkg::blp_stat_t stat,
    input  logic [15:0]      box_length,
    input  logic [15:0]      box_width,
    input  logic [15:0]      box_height,
    input  logic [15:0]      cont_l,
    input  logic [15:0]      cont_w,
    input  logic [15:0]      cont_h,
    input  logic [CW-1:0]    tent_count,
    input  logic             wr_en,
    output logic [15:0]      cand_x,
    output logic [15:0]      cand_y,
    output logic [15:0]      cand_z
);
    logic [47:0] org_mem [MAX_BOXES];
    logic [47:0] ext_mem [MAX_BOXES];
    logic [47:0] org_rd_reg, ext_rd_reg;
    logic [15:0] el_reg, ew_reg, eh_reg;
    logic [15:0] cx_reg, cy_reg, cz_reg;
    logic [CW-1:0] cbox_reg;
    logic [1:0] face_reg;
    logic [CW-1:0] sidx_reg;
    logic [CW-1:0] sidx_inc;
    logic [IW-1:0] raddr;
    logic rd_valid_reg;
    logic [16:0] sx, sy, sz, ox, oy, oz;
    logic apart;
    logic [16:0] nx, ny, nz;

    always_comb
    begin
        sidx_inc = sidx_reg + 1'b1;
        raddr = cmd.scan_start ? '0 :
                (cmd.cand_start || cmd.cand_next) ? cbox_reg[IW-1:0] : sidx_inc[IW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            org_mem[tent_count[IW-1:0]] <= {cz_reg, cy_reg, cx_reg};
            ext_mem[tent_count[IW-1:0]] <= {eh_reg, ew_reg, el_reg};
        end
        org_rd_reg <= org_mem[raddr];
        ext_rd_reg <= ext_mem[raddr];
    end

    always_comb
    begin
        sx = {1'b0, cx_reg} + {1'b0, el_reg};
        sy = {1'b0, cy_reg} + {1'b0, ew_reg};
        sz = {1'b0, cz_reg} + {1'b0, eh_reg};
        ox = {1'b0, org_rd_reg[15:0]} + {1'b0, ext_rd_reg[15:0]};
        oy = {1'b0, org_rd_reg[31:16]} + {1'b0, ext_rd_reg[31:16]};
        oz = {1'b0, org_rd_reg[47:32]} + {1'b0, ext_rd_reg[47:32]};
        apart = (sx <= {1'b0, org_rd_reg[15:0]}) || (ox <= {1'b0, cx_reg})
             || (sy <= {1'b0, org_rd_reg[31:16]}) || (oy <= {1'b0, cy_reg})
             || (sz <= {1'b0, org_rd_reg[47:32]}) || (oz <= {1'b0, cz_reg});
        stat.fits = (sx <= {1'b0, cont_l}) && (sy <= {1'b0, cont_w})
                 && (sz <= {1'b0, cont_h});
        stat.scan_hit = rd_valid_reg && !apart;
        stat.scan_last = (sidx_reg == tent_count);
        stat.cand_last = (cbox_reg == tent_count);
        nx = {1'b0, org_rd_reg[15:0]};
        ny = {1'b0, org_rd_reg[31:16]};
        nz = {1'b0, org_rd_reg[47:32]};
        case (face_reg)
            2'd0: nx = ox;
            2'd1: ny = oy;
            default: nz = oz;
        endcase
    end

    // candidate: load sets origin; cand_start reads box cbox; cand_next applies face
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cbox_reg <= '0;
            face_reg <= '0;
            sidx_reg <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= 1'b0;
            if (cmd.load)
            begin
                cbox_reg <= '0;
                face_reg <= 2'd0;
            end
            if (cmd.cand_next)
            begin
                face_reg <= (face_reg == 2'd2) ? 2'd0 : face_reg + 2'd1;
                if (face_reg == 2'd2)
                    cbox_reg <= cbox_reg + 1'b1;
            end
            if (cmd.scan_start)
            begin
                sidx_reg <= '0;
                rd_valid_reg <= (tent_count != '0);
            end
            else if (cmd.scan_next)
            begin
                sidx_reg <= sidx_reg + 1'b1;
                rd_valid_reg <= (sidx_reg + 1'b1) != tent_count;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            el_reg <= box_length;
            ew_reg <= box_width;
            eh_reg <= box_height;
            cx_reg <= '0;
            cy_reg <= '0;
            cz_reg <= '0;
        end
        else if (cmd.cand_next)
        begin
            cx_reg <= nx[15:0];
            cy_reg <= ny[15:0];
            cz_reg <= nz[15:0];
        end
    end

    assign cand_x = cx_reg;
    assign cand_y = cy_reg;
    assign cand_z = cz_reg;

    `BLP_ASSERT_IMPL(a_face_range, face_reg != 2'd3, "face index out of range")
    `BLP_ASSERT_IMPL(a_scan_bound, !rd_valid_reg || sidx_reg < tent_count, "scan index past table")
    `BLP_ASSERT_NEXT(a_load_origin, cmd.load, cand_x == 16'd0 && cand_y == 16'd0,
        "candidate not at origin after load")
endmodule

FILE: design/blp_ctrl.sv
// Controller: search sequencing, counts and group bookkeeping
`include "bottom_left_3d_box_placer_defines.svh"
module blp_ctrl #(
    parameter int unsigned MAX_BOXES = blp_pkg::MAX_BOXES_DEF,
    localparam int unsigned CW = $clog2(MAX_BOXES + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             group_last,
    output logic             busy,
    output blp_pkg::blp_cmd_t cmd,
    input  blp_pkg::blp_stat_t stat,
    output logic [CW-1:0]    tent_count,
    output logic             wr_en,
    output logic             res_valid,
    output logic             res_placed,
    output logic             res_done,
    output logic             res_ok
);
    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CHECK = 6'b000010,
        S_SCAN = 6'b000100,
        S_FETCH = 6'b001000,
        S_MOVE = 6'b010000,
        S_WAIT = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic [CW-1:0] tent_reg, comm_reg;
    logic failed_reg, last_reg;
    logic finish, ok;

    assign busy = (state_reg != S_IDLE);
    assign tent_count = tent_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        finish = 1'b0;
        ok = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (failed_reg || tent_reg == CW'(MAX_BOXES))
                        finish = 1'b1;
                    else
                        state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.fits)
                begin
                    cmd.scan_start = 1'b1;
                    state_next = S_SCAN;
                end
                else
                    state_next = S_FETCH;
            end
            S_SCAN:
            begin
                if (stat.scan_hit)
                    state_next = S_FETCH;
                else if (stat.scan_last)
                begin
                    ok = 1'b1;
                    finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                    cmd.scan_next = 1'b1;
            end
            S_FETCH:
            begin
                if (stat.cand_last)
                begin
                    finish = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.cand_start = 1'b1;
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                cmd.cand_start = 1'b1;
                state_next = S_MOVE;
            end
            S_MOVE:
            begin
                cmd.cand_next = 1'b1;
                state_next = S_CHECK;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // FETCH issues the read address via cand path; WAIT lets the read settle
    assign wr_en = finish && ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tent_reg <= '0;
            comm_reg <= '0;
            failed_reg <= 1'b0;
            last_reg <= 1'b0;
            res_valid <= 1'b0;
            res_placed <= 1'b0;
            res_done <= 1'b0;
            res_ok <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            res_valid <= finish;
            if (state_reg == S_IDLE && start)
                last_reg <= group_last;
            if (finish)
            begin
                logic lst;
                logic fl;
                lst = (state_reg == S_IDLE) ? group_last : last_reg;
                fl = failed_reg || !ok;
                res_placed <= ok;
                res_done <= lst;
                res_ok <= lst && !fl;
                if (lst)
                begin
                    failed_reg <= 1'b0;
                    if (fl)
                        tent_reg <= comm_reg;
                    else
                    begin
                        tent_reg <= tent_reg + 1'b1;
                        comm_reg <= tent_reg + 1'b1;
                    end
                end
                else if (fl)
                begin
                    failed_reg <= 1'b1;
                    tent_reg <= comm_reg;
                end
                else
                    tent_reg <= tent_reg + 1'b1;
            end
        end
    end

    `BLP_ASSERT_IMPL(a_comm_le_tent, comm_reg <= tent_reg, "committed count above tentative")
    `BLP_ASSERT_NEXT(a_one_result, finish, state_reg == S_IDLE, "result while still searching")
    `BLP_ASSERT_IMPL(a_write_bound, !wr_en || tent_reg < CW'(MAX_BOXES), "write to full table")
endmodule

FILE: design/bottom_left_3d_box_placer.sv
// Top level of the bottom-left 3D box placer
// Usage:
//   Drive box_length/box_width/box_height/group_last with start high while
//   busy is low; the item is taken at that edge. Exactly one result follows,
//   shown for one cycle with done high: pos_x/pos_y/pos_z, placed,
//   group_done and group_ok. The receiver cannot stall the block.
//   A skipped box (failed group or full table) has its result in the cycle
//   after it is taken and busy stays low. A search over N held boxes tries
//   up to 3N+1 corners; each costs a container check, an overlap scan of the
//   table if the box fits there, and, unless it was the last corner, a fetch
//   of the next box and a move of the corner. busy drops in the result
//   cycle, so the next item can be taken then. The overlap scan reads one
//   table entry per cycle from the box memory. Container extents sit in an
//   APB register file (byte addresses 0, 4, 8); they must be written by the
//   user only while busy is low, and the block itself does not enforce this.
//   Reset clears the counts, the group state and sets each container extent
//   to 1024; the box table needs no clearing.
module bottom_left_3d_box_placer #(
    parameter int unsigned MAX_BOXES = blp_pkg::MAX_BOXES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [15:0] box_length,
    input  logic [15:0] box_width,
    input  logic [15:0] box_height,
    input  logic        group_last,
    output logic        done,
    output logic [15:0] pos_x,
    output logic [15:0] pos_y,
    output logic [15:0] pos_z,
    output logic        placed,
    output logic        group_done,
    output logic        group_ok
);
    localparam int unsigned CW = $clog2(MAX_BOXES + 1);
    logic [15:0] len_reg, wid_reg, hgt_reg;
    blp_pkg::blp_cmd_t cmd;
    blp_pkg::blp_stat_t stat;
    logic [CW-1:0] tent_count;
    logic wr_en, res_placed;
    logic [15:0] cx, cy, cz;
    logic [15:0] px_reg, py_reg, pz_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= blp_pkg::CONT_RESET;
            wid_reg <= blp_pkg::CONT_RESET;
            hgt_reg <= blp_pkg::CONT_RESET;
        end
        else if (psel && penable && pwrite && paddr[1:0] == 2'd0)
        begin
            case (paddr[3:2])
                blp_pkg::REG_LENGTH: len_reg <= pwdata[15:0];
                blp_pkg::REG_WIDTH: wid_reg <= pwdata[15:0];
                blp_pkg::REG_HEIGHT: hgt_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            blp_pkg::REG_LENGTH: prdata = {16'd0, len_reg};
            blp_pkg::REG_WIDTH: prdata = {16'd0, wid_reg};
            blp_pkg::REG_HEIGHT: prdata = {16'd0, hgt_reg};
            default: prdata = 32'd0;
        endcase
    end

    blp_ctrl #(.MAX_BOXES(MAX_BOXES)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .group_last(group_last),
        .busy(busy), .cmd(cmd), .stat(stat), .tent_count(tent_count),
        .wr_en(wr_en), .res_valid(done), .res_placed(res_placed),
        .res_done(group_done), .res_ok(group_ok)
    );

    blp_datapath #(.MAX_BOXES(MAX_BOXES)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .box_length(box_length), .box_width(box_width), .box_height(box_height),
        .cont_l(len_reg), .cont_w(wid_reg), .cont_h(hgt_reg),
        .tent_count(tent_count), .wr_en(wr_en),
        .cand_x(cx), .cand_y(cy), .cand_z(cz)
    );

    // hold the chosen corner for the result cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            px_reg <= cx;
            py_reg <= cy;
            pz_reg <= cz;
        end
    end

    assign placed = res_placed;
    assign pos_x = res_placed ? px_reg : 16'd0;
    assign pos_y = res_placed ? py_reg : 16'd0;
    assign pos_z = res_placed ? pz_reg : 16'd0;
endmodule
